FILE: hw/rtl/source_tokenizer_defines.svh
// assertion macros for the source tokenizer
`ifndef SOURCE_TOKENIZER_DEFINES_SVH
`define SOURCE_TOKENIZER_DEFINES_SVH

// property that holds at every clock outside reset
`define ST_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`endif

FILE: hw/rtl/stok_pkg.sv
package stok_pkg;

	localparam int OFFSET_BITS_DEF = 24;
	localparam int OUT_BITS = 24;

	typedef enum logic [2:0] {
		K_STRING  = 3'd0,
		K_KEYWORD = 3'd1,
		K_IDENT   = 3'd2,
		K_INT     = 3'd3,
		K_PUNCT   = 3'd4,
		K_UNTERM  = 3'd5,
		K_LONG    = 3'd6,
		K_END     = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		M_IDLE, M_COMMENT, M_WORD, M_INT, M_STR, M_ESC, M_PUNCT, M_STOP
	} mode_t;

	// one token record
	typedef struct packed {
		kind_t           kind;
		logic [OUT_BITS-1:0] start_offset;
		logic [OUT_BITS-1:0] end_offset;
		logic [OUT_BITS-1:0] line_number;
		logic            final_res;
	} rec_t;

	// up to three records produced by one byte
	typedef struct packed {
		logic [1:0] count;
		rec_t       r0;
		rec_t       r1;
		rec_t       r2;
	} bundle_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return c == 8'h5f || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
		return (a == "-" && b == ">") || (a == "=" && b == "=") || (a == "!" && b == "=")
			|| (a == "<" && b == "=") || (a == ">" && b == "=") || (a == "&" && b == "&")
			|| (a == "|" && b == "|") || (a == "/" && b == "/") || (a == "." && b == ".")
			|| (a == "*" && b == "*") || (a == "?" && b == "?") || (a == "|" && b == ">");
	endfunction

	function automatic logic is_keyword(input logic [63:0] w, input logic [3:0] n);
		return (n == 4'd2 && (w[15:0] == "fn" || w[15:0] == "if" || w[15:0] == "in"))
			|| (n == 4'd3 && (w[23:0] == "let" || w[23:0] == "mut" || w[23:0] == "for"))
			|| (n == 4'd4 && (w[31:0] == "else" || w[31:0] == "true"))
			|| (n == 4'd5 && (w[39:0] == "while" || w[39:0] == "break"
				|| w[39:0] == "false"))
			|| (n == 4'd6 && w[47:0] == "return")
			|| (n == 4'd8 && w == "continue");
	endfunction

endpackage

FILE: hw/rtl/stok_front.sv
module stok_front #(
	parameter int OffsetBits = stok_pkg::OFFSET_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	output logic                 b_valid,
	input  logic                 b_ready,
	output stok_pkg::bundle_t    b_data
);

	localparam logic [OffsetBits-1:0] Limit = {OffsetBits{1'b1}};
	localparam int OB = stok_pkg::OUT_BITS;

	stok_pkg::mode_t           mode_q, mode_d;
	logic [OffsetBits-1:0]     pos_q, tstart_q, tstart_d;
	logic [OffsetBits-1:0]     line_q, tline_q, tline_d, line_d;
	logic [7:0]                pend_q, pend_d;
	logic [63:0]               word_q, word_d;
	logic [3:0]                wlen_q, wlen_d;
	stok_pkg::bundle_t         bun;
	logic                      take;

	assign in_ready = b_ready;
	assign take = in_valid && in_ready;

	function automatic stok_pkg::rec_t mk(input stok_pkg::kind_t k,
			input logic [OffsetBits-1:0] s, input logic [OffsetBits-1:0] e,
			input logic [OffsetBits-1:0] l, input logic f);
		stok_pkg::rec_t r;
		r.kind = k;
		r.start_offset = OB'(s);
		r.end_offset = OB'(e);
		r.line_number = OB'(l);
		r.final_res = f;
		return r;
	endfunction

	// per-byte classification and record building
	always_comb begin
		logic [OffsetBits-1:0] p1;
		logic                  restart;
		logic                  flush;
		logic [OffsetBits-1:0] fend;
		stok_pkg::rec_t        recs [3];
		logic [1:0]            n;
		stok_pkg::mode_t       m;
		p1 = pos_q + 1'b1;
		restart = 1'b0;
		flush = 1'b0;
		fend = pos_q;
		n = 2'd0;
		recs[0] = '0;
		recs[1] = '0;
		recs[2] = '0;
		mode_d = mode_q;
		tstart_d = tstart_q;
		tline_d = tline_q;
		pend_d = pend_q;
		word_d = word_q;
		wlen_d = wlen_q;
		line_d = (in_byte == 8'h0a) ? line_q + 1'b1 : line_q;
		m = mode_q;
		if (mode_q == stok_pkg::M_STOP) begin
			line_d = line_q;
		end else if (pos_q == Limit) begin
			recs[0] = mk(stok_pkg::K_LONG, pos_q, pos_q, line_q, 1'b1);
			n = 2'd1;
			mode_d = stok_pkg::M_STOP;
			line_d = line_q;
		end else begin
			unique case (mode_q)
				stok_pkg::M_COMMENT: if (in_byte == 8'h0a) m = stok_pkg::M_IDLE;
				stok_pkg::M_STR: begin
					if (in_byte == 8'h5c) m = stok_pkg::M_ESC;
					else if (in_byte == 8'h22) begin
						recs[0] = mk(stok_pkg::K_STRING, tstart_q, p1, tline_q, 1'b0);
						n = 2'd1;
						m = stok_pkg::M_IDLE;
					end else if (in_byte == 8'h0a) begin
						recs[0] = mk(stok_pkg::K_UNTERM, tstart_q, p1, tline_q, 1'b1);
						n = 2'd1;
						m = stok_pkg::M_STOP;
					end
				end
				stok_pkg::M_ESC: m = stok_pkg::M_STR;
				stok_pkg::M_WORD: begin
					if (stok_pkg::is_alpha(in_byte) || stok_pkg::is_digit(in_byte)) begin
						if (wlen_q < 4'd8) begin
							word_d = {word_q[55:0], in_byte};
							wlen_d = wlen_q + 4'd1;
						end else wlen_d = 4'd9;
					end else begin
						flush = 1'b1;
						restart = 1'b1;
					end
				end
				stok_pkg::M_INT: if (!(stok_pkg::is_digit(in_byte) || in_byte == 8'h5f)) begin
					flush = 1'b1;
					restart = 1'b1;
				end
				stok_pkg::M_PUNCT: begin
					flush = 1'b1;
					if (stok_pkg::is_pair(pend_q, in_byte)) fend = p1;
					else restart = 1'b1;
				end
				default: restart = 1'b1;
			endcase
			// emit the token closed by this byte
			if (flush) begin
				unique case (mode_q)
					stok_pkg::M_WORD: recs[0] = mk(stok_pkg::is_keyword(word_q, wlen_q)
						? stok_pkg::K_KEYWORD : stok_pkg::K_IDENT, tstart_q, fend, tline_q, 1'b0);
					stok_pkg::M_INT: recs[0] = mk(stok_pkg::K_INT, tstart_q, fend, tline_q, 1'b0);
					default: recs[0] = mk(stok_pkg::K_PUNCT, tstart_q, fend, tline_q, 1'b0);
				endcase
				n = 2'd1;
				m = stok_pkg::M_IDLE;
			end
			// start a new token from idle
			if (restart) begin
				m = stok_pkg::M_IDLE;
				if (stok_pkg::is_space(in_byte)) m = stok_pkg::M_IDLE;
				else if (in_byte == 8'h23) m = stok_pkg::M_COMMENT;
				else begin
					tstart_d = pos_q;
					tline_d = line_q;
					if (in_byte == 8'h22) m = stok_pkg::M_STR;
					else if (stok_pkg::is_alpha(in_byte)) begin
						m = stok_pkg::M_WORD;
						word_d = {56'd0, in_byte};
						wlen_d = 4'd1;
					end else if (stok_pkg::is_digit(in_byte)) m = stok_pkg::M_INT;
					else begin
						m = stok_pkg::M_PUNCT;
						pend_d = in_byte;
					end
				end
			end
			// end of source
			if (in_last && m != stok_pkg::M_STOP) begin
				if (m == stok_pkg::M_STR || m == stok_pkg::M_ESC) begin
					recs[n] = mk(stok_pkg::K_UNTERM, tstart_d, p1, tline_d, 1'b1);
					n = n + 2'd1;
				end else begin
					if (m == stok_pkg::M_WORD || m == stok_pkg::M_INT
							|| m == stok_pkg::M_PUNCT) begin
						recs[n] = mk(m == stok_pkg::M_INT ? stok_pkg::K_INT
							: m == stok_pkg::M_PUNCT ? stok_pkg::K_PUNCT
							: stok_pkg::is_keyword(word_d, wlen_d) ? stok_pkg::K_KEYWORD
							: stok_pkg::K_IDENT, tstart_d, p1, tline_d, 1'b0);
						n = n + 2'd1;
					end
					recs[n] = mk(stok_pkg::K_END, p1, p1, line_d, 1'b1);
					n = n + 2'd1;
				end
				m = stok_pkg::M_STOP;
			end
			mode_d = m;
		end
		bun.count = n;
		bun.r0 = recs[0];
		bun.r1 = recs[1];
		bun.r2 = recs[2];
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stok_pkg::M_IDLE;
			pos_q <= '0;
			line_q <= OffsetBits'(1);
			tstart_q <= '0;
			tline_q <= OffsetBits'(1);
			pend_q <= '0;
			word_q <= '0;
			wlen_q <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			if (mode_q != stok_pkg::M_STOP && pos_q != Limit) pos_q <= pos_q + 1'b1;
			line_q <= line_d;
			tstart_q <= tstart_d;
			tline_q <= tline_d;
			pend_q <= pend_d;
			word_q <= word_d;
			wlen_q <= wlen_d;
		end
	end

	// only bytes that yield records enter the queue
	assign b_valid = take && bun.count != 2'd0;
	assign b_data = bun;

endmodule

FILE: hw/rtl/stok_back.sv
`include "source_tokenizer_defines.svh"
module stok_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              b_valid,
	output logic              b_ready,
	input  stok_pkg::bundle_t b_data,
	output logic              out_valid,
	input  logic              out_ready,
	output stok_pkg::rec_t    out_rec
);

	// two-entry queue of bundles; a bundle is taken while a slot is free or
	// the head bundle leaves in the same cycle
	stok_pkg::bundle_t slot_q [2];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;
	logic [1:0]        sub_q;
	stok_pkg::bundle_t head;
	logic              pop, push;

	assign head = slot_q[rp_q];
	assign b_ready = (cnt_q != 2'd2) || pop;
	assign push = b_valid && b_ready;
	assign out_valid = cnt_q != 2'd0;
	assign out_rec = (sub_q == 2'd0) ? head.r0 : (sub_q == 2'd1) ? head.r1 : head.r2;
	assign pop = out_valid && out_ready && (sub_q + 2'd1 == head.count);

	// queue storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= b_data;
	end

	// pointers and record index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
			sub_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (pop) sub_q <= 2'd0;
			else if (out_valid && out_ready) sub_q <= sub_q + 2'd1;
		end
	end

	`ST_ASSERT(a_cnt_range, cnt_q != 2'd3, "queue count overflow")
	`ST_ASSERT(a_sub_range, !out_valid || sub_q < head.count, "record index past bundle")
	`ST_ASSERT(a_push_nonempty, !push || b_data.count != 2'd0, "empty bundle queued")

endmodule

FILE: hw/rtl/source_tokenizer.sv
// channel  | dir | tdata (low bit up)                                | tuser
// s_axis   | in  | byte_req[7:0]                                     | -
//          |     | tlast = last                                      |
// m_axis   | out | kind[2:0] start_offset end_offset line_number     | -
//          |     | tlast = final_res                                 |
// one byte per cycle is accepted while s_axis_tready is high; its
// records are registered in the bundle queue and leave one record per
// cycle while m_axis_tready is high; a byte with two or three records
// holds the head until all leave; the two-entry queue absorbs this; input
// stalls only when both entries are full and the head bundle stays in that cycle
// reset clears lexer state and the queue
module source_tokenizer #(
	parameter int OFFSET_BITS = stok_pkg::OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // byte_req
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // kind, start_offset, end_offset, line_number, zeros
	output logic        m_axis_tlast
);

	logic              b_valid, b_ready;
	stok_pkg::bundle_t b_data;
	stok_pkg::rec_t    rec;

	stok_front #(.OffsetBits(OFFSET_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_byte(s_axis_tdata), .in_last(s_axis_tlast),
		.b_valid, .b_ready, .b_data
	);

	stok_back u_back (
		.clk, .arst_n, .b_valid, .b_ready, .b_data,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rec(rec)
	);

	assign m_axis_tdata = {5'd0, rec.line_number, rec.end_offset, rec.start_offset, rec.kind};
	assign m_axis_tlast = rec.final_res;

endmodule
